FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the core folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checks that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: rtl/core/tddm_pkg.sv
// ----------------------------------------------------------------------------
// tddm_pkg
// Types and codes of the table-driven DFA matcher: request and response
// items, request codes, register indexes and memory entry layout.
// ----------------------------------------------------------------------------
package tddm_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int STATE_W    = 8;
   localparam int SYM_W      = 6;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_COUNT = 1'b1;

   // Request codes.
   localparam logic [2:0] REQ_LOAD_SYMBOL = 3'd0;
   localparam logic [2:0] REQ_LOAD_TRANS  = 3'd1;
   localparam logic [2:0] REQ_LOAD_ACCEPT = 3'd2;
   localparam logic [2:0] REQ_TEXT_BYTE   = 3'd3;
   localparam logic [2:0] REQ_EMPTY_TEXT  = 3'd4;

   // Byte enables of the auxiliary memory: symbol map part and accept flag.
   localparam logic [1:0] AUX_WEN_NONE = 2'b00;
   localparam logic [1:0] AUX_WEN_SYM  = 2'b01;
   localparam logic [1:0] AUX_WEN_ACC  = 2'b10;
   localparam logic [1:0] AUX_WEN_ALL  = 2'b11;

   localparam int AUX_ACC_BIT   = 7;
   localparam int AUX_VALID_BIT = 6;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [7:0]         byte_value;
      logic [SYM_W-1:0]   symbol_slot;
      logic               symbol_present;
      logic [STATE_W-1:0] state_slot;
      logic [STATE_W-1:0] target_state;
      logic               target_present;
      logic               accepting_bit;
      logic               text_end;
   } tddm_req_type;

   typedef struct packed {
      logic accepted;
      logic status;
   } tddm_rsp_type;

endpackage

FILE: rtl/core/table_driven_dfa_matcher_core.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_matcher_core: table-driven DFA acceptor with loadable tables.
// A load is written as it is accepted. A text byte of a live text does a symbol map
// read, then the dependent transition table read; a last byte, and an empty text,
// strobe their result after a finishing step. Reset runs a clearing pass over
// max(MAX_SYMBOLS*MAX_STATES, 256) addresses with busy high; 16384 by default.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_driven_dfa_matcher_core
   import tddm_pkg::*;
#(
   parameter int MAX_STATES  = 256,
   parameter int MAX_SYMBOLS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tddm_req_type          req_data,
   output logic                  rsp_valid,
   output tddm_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TT_DEPTH  = MAX_SYMBOLS * MAX_STATES;
   localparam int TAW       = $clog2(TT_DEPTH);
   localparam int AUX_DEPTH = (MAX_STATES > 256) ? MAX_STATES : 256;
   localparam int XAW       = $clog2(AUX_DEPTH);
   localparam int CLR_DEPTH = (TT_DEPTH > AUX_DEPTH) ? TT_DEPTH : AUX_DEPTH;
   localparam int CAW       = $clog2(CLR_DEPTH);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SYM  = 3'd2;
   localparam logic [2:0] S_TRN  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CAW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [STATE_W-1:0]    start_state_ff;
   logic [CSR_DATA_W-1:0] state_count_ff;
   logic [STATE_W-1:0]    cur_ff, cur_in;
   logic                  rej_ff, rej_in;
   logic                  flt_ff, flt_in;
   logic                  in_text_ff, in_text_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tddm_rsp_type          rsp_data_ff, rsp_data_in;

   // Transition table: {valid, target state}, indexed by symbol and state.
   logic [STATE_W:0]      tt_mem [TT_DEPTH];
   logic                  tt_we, tt_re;
   logic [TAW-1:0]        tt_waddr, tt_raddr;
   logic [STATE_W:0]      tt_wdata, tt_rdata_ff;

   // Auxiliary memory: {accept flag of a state, symbol valid, symbol of a byte}.
   logic [7:0]            aux_mem [AUX_DEPTH];
   logic [1:0]            aux_wen;
   logic                  aux_re;
   logic [XAW-1:0]        aux_waddr, aux_raddr;
   logic [7:0]            aux_wdata, aux_rdata_ff;

   logic                  accept;
   logic [STATE_W-1:0]    eff_cur;
   logic                  eff_rej, eff_flt;
   logic [STATE_W-1:0]    next_cur;
   logic [SYM_W-1:0]      rd_sym;

   function automatic logic state_bad(input logic [STATE_W-1:0] s,
                                      input logic [CSR_DATA_W-1:0] cnt);
      return ({1'b0, s} >= cnt) || (32'(s) >= MAX_STATES);
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The first byte of a text starts from start_state with clean flags.
   assign eff_cur  = in_text_ff ? cur_ff : start_state_ff;
   assign eff_rej  = in_text_ff ? rej_ff : 1'b0;
   assign eff_flt  = in_text_ff ? flt_ff : 1'b0;
   assign next_cur = tt_rdata_ff[STATE_W] ? tt_rdata_ff[STATE_W-1:0] : cur_ff;
   assign rd_sym   = aux_rdata_ff[SYM_W-1:0];

   // The sequencer takes a new item only in idle, so a load never overlaps a
   // read of the same memory and no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cur_in       = cur_ff;
      rej_in       = rej_ff;
      flt_in       = flt_ff;
      in_text_in   = in_text_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      tt_we        = 1'b0;
      tt_waddr     = '0;
      tt_wdata     = '0;
      tt_re        = 1'b0;
      tt_raddr     = '0;
      aux_wen      = AUX_WEN_NONE;
      aux_waddr    = '0;
      aux_wdata    = '0;
      aux_re       = 1'b0;
      aux_raddr    = '0;

      unique case (state_ff)
         S_CLR: begin
            tt_we     = (32'(clr_cnt_ff) < TT_DEPTH);
            tt_waddr  = clr_cnt_ff[TAW-1:0];
            aux_wen   = (32'(clr_cnt_ff) < AUX_DEPTH) ? AUX_WEN_ALL : AUX_WEN_NONE;
            aux_waddr = clr_cnt_ff[XAW-1:0];
            if (clr_cnt_ff == CAW'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_LOAD_SYMBOL: begin
                     if (32'(req_data.symbol_slot) < MAX_SYMBOLS) begin
                        aux_wen = AUX_WEN_SYM;
                     end
                     aux_waddr = XAW'(req_data.byte_value);
                     aux_wdata = {1'b0, req_data.symbol_present, req_data.symbol_slot};
                  end
                  REQ_LOAD_TRANS: begin
                     tt_we    = (32'(req_data.symbol_slot) < MAX_SYMBOLS) &&
                                (32'(req_data.state_slot) < MAX_STATES);
                     tt_waddr = TAW'(32'(req_data.symbol_slot) * MAX_STATES +
                                     32'(req_data.state_slot));
                     tt_wdata = {req_data.target_present, req_data.target_state};
                  end
                  REQ_LOAD_ACCEPT: begin
                     if (32'(req_data.state_slot) < MAX_STATES) begin
                        aux_wen = AUX_WEN_ACC;
                     end
                     aux_waddr = XAW'(req_data.state_slot);
                     aux_wdata = {req_data.accepting_bit, 7'd0};
                  end
                  REQ_TEXT_BYTE: begin
                     in_text_in = 1'b1;
                     cur_in     = eff_cur;
                     rej_in     = eff_rej;
                     flt_in     = eff_flt;
                     last_in    = req_data.text_end;
                     if (!eff_rej && !eff_flt && state_bad(eff_cur, state_count_ff)) begin
                        flt_in = 1'b1;
                     end
                     if (!eff_rej && !eff_flt && !state_bad(eff_cur, state_count_ff)) begin
                        aux_re    = 1'b1;
                        aux_raddr = XAW'(req_data.byte_value);
                        state_in  = S_SYM;
                     end else if (req_data.text_end) begin
                        aux_re    = 1'b1;
                        aux_raddr = XAW'(eff_cur);
                        state_in  = S_FIN;
                     end
                  end
                  REQ_EMPTY_TEXT: begin
                     cur_in     = start_state_ff;
                     rej_in     = 1'b0;
                     flt_in     = 1'b0;
                     in_text_in = 1'b0;
                     aux_re     = 1'b1;
                     aux_raddr  = XAW'(start_state_ff);
                     state_in   = S_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SYM: begin
            if (!aux_rdata_ff[AUX_VALID_BIT] || (32'(rd_sym) >= MAX_SYMBOLS)) begin
               rej_in = 1'b1;
               if (last_ff) begin
                  aux_re    = 1'b1;
                  aux_raddr = XAW'(cur_ff);
                  state_in  = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               tt_re    = 1'b1;
               tt_raddr = TAW'(32'(rd_sym) * MAX_STATES + 32'(cur_ff));
               state_in = S_TRN;
            end
         end
         S_TRN: begin
            rej_in = !tt_rdata_ff[STATE_W];
            cur_in = next_cur;
            if (last_ff) begin
               aux_re    = 1'b1;
               aux_raddr = XAW'(next_cur);
               state_in  = S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            in_text_in   = 1'b0;
            state_in     = S_IDLE;
            if (rej_ff) begin
               rsp_data_in.accepted = 1'b0;
               rsp_data_in.status   = 1'b0;
            end else if (flt_ff || state_bad(cur_ff, state_count_ff)) begin
               rsp_data_in.accepted = 1'b0;
               rsp_data_in.status   = 1'b1;
            end else begin
               rsp_data_in.accepted = aux_rdata_ff[AUX_ACC_BIT];
               rsp_data_in.status   = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         cur_ff       <= '0;
         rej_ff       <= 1'b0;
         flt_ff       <= 1'b0;
         in_text_ff   <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cur_ff       <= cur_in;
         rej_ff       <= rej_in;
         flt_ff       <= flt_in;
         in_text_ff   <= in_text_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         state_count_ff <= CSR_DATA_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_STATE: start_state_ff <= csr_wdata[STATE_W-1:0];
            CSR_STATE_COUNT: state_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tt_we) begin
         tt_mem[tt_waddr] <= tt_wdata;
      end
      if (tt_re) begin
         tt_rdata_ff <= tt_mem[tt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (aux_wen[0]) begin
         aux_mem[aux_waddr][6:0] <= aux_wdata[6:0];
      end
      if (aux_wen[1]) begin
         aux_mem[aux_waddr][AUX_ACC_BIT] <= aux_wdata[AUX_ACC_BIT];
      end
      if (aux_re) begin
         aux_rdata_ff <= aux_mem[aux_raddr];
      end
   end

   `ASSERT_CLK(a_rsp_from_fin, clock, reset, rsp_valid |-> $past(state_ff == S_FIN), "result strobe without a finishing step")
   `ASSERT_CLK(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_NEVER(a_tt_rw_overlap, clock, reset, tt_we && tt_re, "transition table read and written in one cycle")
   `ASSERT_NEVER(a_aux_rw_overlap, clock, reset, aux_re && (aux_wen != AUX_WEN_NONE), "symbol map read and written in one cycle")

endmodule

FILE: sim/tb_table_driven_dfa_matcher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_driven_dfa_matcher_core
// Self-checking bench for the DFA matcher core. Small automata are loaded
// through the request port and texts are run against them. Every verdict is
// compared with a behavioral prediction of the tables, the text progress and
// the state limit, across several start state and state count settings.
// ----------------------------------------------------------------------------
module tb_table_driven_dfa_matcher_core;
   import tddm_pkg::*;

   localparam int N_STATES     = 256;
   localparam int N_SYMBOLS    = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int REQ_W        = $bits(tddm_req_type);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   tddm_req_type          req_data;
   logic                  rsp_valid;
   tddm_rsp_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   table_driven_dfa_matcher_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Acceptor model: registers, text progress and the three stores.
   logic [7:0] cfg_start_state;
   logic [8:0] cfg_state_count;
   logic [7:0] dfa_state;
   logic       text_rejected;
   logic       text_faulted;
   logic       text_open;
   logic [6:0] symbol_of_byte [256];                   // bit 6 marks a valid entry
   logic [8:0] next_state_of [N_SYMBOLS * N_STATES];   // bit 8 marks a valid entry
   logic       state_accepts [N_STATES];

   tddm_rsp_type pending_verdicts [$];
   tddm_rsp_type oldest_verdict;
   int           mismatch_count  = 0;
   int           sender_idle_pct = 0;
   int           items_sent      = 0;

   // States and mapped bytes of the automaton loaded for a random phase.
   logic [7:0] dfa_states [8];
   int         dfa_state_num;
   logic [7:0] alphabet_bytes [$];

   always #6 clock = ~clock;

   function automatic tddm_req_type random_fields();
      logic [REQ_W-1:0] raw;
      raw = REQ_W'({$urandom, $urandom});
      return tddm_req_type'(raw);
   endfunction

   function automatic tddm_req_type load_symbol(logic [7:0] byte_v, logic [5:0] slot,
                                                logic present);
      tddm_req_type r;
      r = random_fields();
      r.req_type       = REQ_LOAD_SYMBOL;
      r.byte_value     = byte_v;
      r.symbol_slot    = slot;
      r.symbol_present = present;
      return r;
   endfunction

   function automatic tddm_req_type load_transition(logic [5:0] slot, logic [7:0] src,
                                                    logic [7:0] dst, logic present);
      tddm_req_type r;
      r = random_fields();
      r.req_type       = REQ_LOAD_TRANS;
      r.symbol_slot    = slot;
      r.state_slot     = src;
      r.target_state   = dst;
      r.target_present = present;
      return r;
   endfunction

   function automatic tddm_req_type load_accept(logic [7:0] src, logic flag);
      tddm_req_type r;
      r = random_fields();
      r.req_type      = REQ_LOAD_ACCEPT;
      r.state_slot    = src;
      r.accepting_bit = flag;
      return r;
   endfunction

   function automatic tddm_req_type text_byte(logic [7:0] byte_v, logic last);
      tddm_req_type r;
      r = random_fields();
      r.req_type   = REQ_TEXT_BYTE;
      r.byte_value = byte_v;
      r.text_end   = last;
      return r;
   endfunction

   function automatic tddm_req_type empty_text();
      tddm_req_type r;
      r = random_fields();
      r.req_type = REQ_EMPTY_TEXT;
      return r;
   endfunction

   function automatic logic [8:0] state_limit();
      return (cfg_state_count < 9'(N_STATES)) ? cfg_state_count : 9'(N_STATES);
   endfunction

   // Verdict at the end of a text: a rejection wins over an out-of-range state.
   function automatic tddm_rsp_type end_verdict();
      tddm_rsp_type v;
      v = '0;
      if (text_rejected) begin
         v = '0;
      end else if (text_faulted || {1'b0, dfa_state} >= state_limit()) begin
         v.status = 1'b1;
      end else begin
         v.accepted = state_accepts[dfa_state];
      end
      return v;
   endfunction

   task automatic reset_acceptor();
      cfg_start_state = 8'd0;
      cfg_state_count = 9'd256;
      dfa_state       = 8'd0;
      text_rejected   = 1'b0;
      text_faulted    = 1'b0;
      text_open       = 1'b0;
      foreach (symbol_of_byte[i]) symbol_of_byte[i] = '0;
      foreach (next_state_of[i]) next_state_of[i] = '0;
      foreach (state_accepts[i]) state_accepts[i] = 1'b0;
   endtask

   task automatic advance_acceptor(input tddm_req_type r);
      logic [6:0] sym_entry;
      logic [8:0] next_entry;
      case (r.req_type)
         REQ_LOAD_SYMBOL: begin
            symbol_of_byte[r.byte_value] = r.symbol_present ? {1'b1, r.symbol_slot} : 7'd0;
         end
         REQ_LOAD_TRANS: begin
            next_state_of[{r.symbol_slot, r.state_slot}] =
               r.target_present ? {1'b1, r.target_state} : 9'd0;
         end
         REQ_LOAD_ACCEPT: begin
            state_accepts[r.state_slot] = r.accepting_bit;
         end
         REQ_TEXT_BYTE: begin
            if (!text_open) begin
               dfa_state     = cfg_start_state;
               text_rejected = 1'b0;
               text_faulted  = 1'b0;
               text_open     = 1'b1;
            end
            // The current state is checked before the byte is looked up.
            if (!text_rejected && !text_faulted) begin
               if ({1'b0, dfa_state} >= state_limit()) begin
                  text_faulted = 1'b1;
               end else begin
                  sym_entry = symbol_of_byte[r.byte_value];
                  if (!sym_entry[6]) begin
                     text_rejected = 1'b1;
                  end else begin
                     next_entry = next_state_of[{sym_entry[5:0], dfa_state}];
                     if (!next_entry[8]) text_rejected = 1'b1;
                     else dfa_state = next_entry[7:0];
                  end
               end
            end
            if (r.text_end) begin
               pending_verdicts.push_back(end_verdict());
               text_open = 1'b0;
            end
         end
         REQ_EMPTY_TEXT: begin
            dfa_state     = cfg_start_state;
            text_rejected = 1'b0;
            text_faulted  = 1'b0;
            text_open     = 1'b0;
            pending_verdicts.push_back(end_verdict());
         end
         default: begin
         end
      endcase
   endtask

   // Start stays high from one item to the next unless the sender pauses.
   task automatic send_item(input tddm_req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      advance_acceptor(r);
      items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      // Loads give no verdict, so let the last of them settle as well.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] start_word,
                             input logic [CSR_DATA_W-1:0] count_word);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_START_STATE;
      csr_wdata <= start_word;
      do @(posedge clock); while (!csr_ready);
      cfg_start_state = start_word[7:0];
      csr_index <= CSR_STATE_COUNT;
      csr_wdata <= count_word;
      do @(posedge clock); while (!csr_ready);
      cfg_state_count = count_word;
      csr_valid <= 1'b0;
   endtask

   // Response checker: the receiver cannot stall, so every strobe is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: verdict with none expected: accepted=%0b status=%0b",
                     $time, rsp_data.accepted, rsp_data.status);
            mismatch_count++;
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_data.accepted !== oldest_verdict.accepted) begin
               $display("%0t: accepted mismatch: expected %0b, actual %0b",
                        $time, oldest_verdict.accepted, rsp_data.accepted);
               mismatch_count++;
            end
            if (rsp_data.status !== oldest_verdict.status) begin
               $display("%0t: status mismatch: expected %0b, actual %0b",
                        $time, oldest_verdict.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_table_loads();
      set_config(9'd0, 9'd256);
      send_item(empty_text());
      send_item(text_byte(8'h00, 1'b1));
      send_item(load_symbol(8'hFF, 6'd63, 1'b1));
      send_item(load_transition(6'd63, 8'd0, 8'd255, 1'b1));
      send_item(load_accept(8'd255, 1'b1));
      send_item(text_byte(8'hFF, 1'b1));
      // Unused request codes must leave no trace, even with text_end set.
      for (int c = 5; c < 8; c++) begin
         send_item(tddm_req_type'({3'(c), {(REQ_W - 4){1'b1}}, 1'b1}));
      end
   endtask

   task automatic test_texts_and_rejection();
      send_item(load_symbol(8'h00, 6'd0, 1'b1));
      send_item(load_transition(6'd0, 8'd255, 8'hAA, 1'b0));
      send_item(text_byte(8'hFF, 1'b0));
      send_item(text_byte(8'h00, 1'b1));
      // An empty text abandons the open one.
      send_item(text_byte(8'hFF, 1'b0));
      send_item(empty_text());
      send_item(load_accept(8'd0, 1'b1));
      send_item(empty_text());
      // Loads inside a text take effect at once.
      send_item(text_byte(8'hFF, 1'b0));
      send_item(load_transition(6'd63, 8'd255, 8'd0, 1'b1));
      send_item(load_accept(8'd255, 1'b0));
      send_item(text_byte(8'hFF, 1'b1));
      send_item(load_symbol(8'h00, 6'd42, 1'b0));
      send_item(text_byte(8'h00, 1'b1));
   endtask

   task automatic test_state_limit_errors();
      // A target beyond the limit is taken and only flagged at the next check.
      set_config(9'd0, 9'd1);
      send_item(text_byte(8'hFF, 1'b1));
      send_item(text_byte(8'hFF, 1'b0));
      send_item(text_byte(8'hFF, 1'b1));
      set_config(9'd0, 9'd0);
      send_item(empty_text());
      send_item(text_byte(8'h00, 1'b1));
      set_config(9'h1FF, 9'h1FF);
      send_item(empty_text());
      send_item(load_accept(8'd255, 1'b1));
      send_item(empty_text());
      send_item(text_byte(8'hFF, 1'b1));
   endtask

   task automatic test_random_texts(input int idle_pct, input logic [8:0] start_word,
                                    input logic [8:0] count_word, input int n_items);
      logic [5:0]   slots [6];
      logic [7:0]   b;
      tddm_req_type r;
      int           n_sym;
      int           len;
      int           pick;
      int           limit;
      int           goal;
      sender_idle_pct = idle_pct;
      set_config(start_word, count_word);
      limit = (count_word < 9'd256) ? int'(count_word) : N_STATES;
      goal  = items_sent + n_items;

      // A small automaton, mostly within the state limit.
      dfa_state_num = $urandom_range(2, 8);
      dfa_states[0] = start_word[7:0];
      for (int k = 1; k < dfa_state_num; k++) begin
         dfa_states[k] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(limit - 1));
      end
      n_sym = $urandom_range(1, 6);
      alphabet_bytes.delete();
      for (int s = 0; s < n_sym; s++) begin
         slots[s] = 6'($urandom_range(N_SYMBOLS - 1));
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(255));
            send_item(load_symbol(b, slots[s], 1'b1));
            alphabet_bytes.push_back(b);
         end
      end
      for (int s = 0; s < n_sym; s++) begin
         for (int k = 0; k < dfa_state_num; k++) begin
            send_item(load_transition(slots[s], dfa_states[k],
                                      dfa_states[$urandom_range(dfa_state_num - 1)],
                                      $urandom_range(19) != 0));
         end
      end
      for (int k = 0; k < dfa_state_num; k++) begin
         send_item(load_accept(dfa_states[k], 1'($urandom_range(1))));
      end

      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(49) == 0) begin
                  r = random_fields();
                  r.req_type = 3'($urandom_range(2));
                  send_item(r);
               end else if ($urandom_range(49) == 0) begin
                  send_item(empty_text());
               end
               b = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                   : alphabet_bytes[$urandom_range(alphabet_bytes.size() - 1)];
               send_item(text_byte(b, i == len - 1));
            end
         end else if (pick < 80) begin
            send_item(empty_text());
         end else if (pick < 88) begin
            r = random_fields();
            r.req_type = 3'($urandom_range(2));
            send_item(r);
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 4)) begin
               r = random_fields();
               r.req_type = REQ_TEXT_BYTE;
               send_item(r);
            end
         end else begin
            // Ignored codes do not count toward the phase length.
            r = random_fields();
            r.req_type = 3'($urandom_range(5, 7));
            send_item(r);
            items_sent--;
         end
      end
      send_item(empty_text());
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_acceptor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_table_loads();
      test_texts_and_rejection();
      test_state_limit_errors();
      test_random_texts(32, {1'b0, 8'($urandom_range(255))}, 9'd256, 280);
      test_random_texts(54, 9'($urandom_range(15)), 9'd16, 280);
      test_random_texts(0, 9'h1FF, 9'd300, 280);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Covers the clearing pass after reset and the slowest legal run, with margin.
   initial begin
      #3_600_000;
      $display("simulation failed");
      $finish;
   end

endmodule
